// ----- sv/dsbc_pkg.sv -----
// shared constants and types for the dempster-shafer binary combiner
// used by dsbc_div_lane and dempster_shafer_binary_combiner_core
`timescale 1ns / 1ps

package dsbc_pkg;

  // width of every mass field on the ports and in the combined state
  localparam int MASS_W = 16;
  // quotient bits produced per normalization (one more than a mass, for the cap)
  localparam int QUO_W = 17;
  // bit-serial multiply steps: widest multiplier operand is a sum of three masses
  localparam int MUL_STEPS = 18;
  // product accumulators: sum of several 18 x 18 bit products
  localparam int ACC_W = 37;
  // step counter, holds up to MUL_STEPS - 1
  localparam int CNT_W = 5;

  // control from the sequencer to each division lane
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// ----- sv/dsbc_div_lane.sv -----
// one radix-2 restoring division lane: cap((num << FRAC_BITS) / den)
// depends on dsbc_pkg
`timescale 1ns / 1ps

module dsbc_div_lane #(
  parameter int FRAC_BITS = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dsbc_pkg::div_ctrl_t          ctrl_i,
  input  logic [dsbc_pkg::MASS_W-1:0]  num_i,
  input  logic [FRAC_BITS:0]           den_i,
  output logic [dsbc_pkg::MASS_W-1:0]  quo_o
);

  localparam int NW = dsbc_pkg::MASS_W + FRAC_BITS;
  localparam int RW = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 1;
  localparam int QW = dsbc_pkg::QUO_W;
  localparam logic [63:0] ONE_64 = 64'd1 << FRAC_BITS;
  localparam logic [dsbc_pkg::MASS_W-1:0] SAT =
    (FRAC_BITS <= 15) ? dsbc_pkg::MASS_W'(ONE_64) : '1;

  logic [NW-1:0] dividend;
  logic [RW-1:0] rem_q;
  logic [QW-1:0] low_q;
  logic [QW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic          ovf_q;
  logic [RW-1:0] rem_sh;
  logic          fits;

  assign dividend = {num_i, {FRAC_BITS{1'b0}}};
  assign rem_sh   = {rem_q[RW-2:0], low_q[QW-1]};
  assign fits     = rem_sh >= RW'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (ctrl_i.load) begin
      // quotient of 2^17 or more ends up at the cap anyway
      ovf_q <= (dividend >> QW) >= NW'(den_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q <= RW'(dividend >> QW);
      low_q <= dividend[QW-1:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q <= fits ? (rem_sh - RW'(den_q)) : rem_sh;
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign quo_o = (ovf_q || (quo_q > QW'(SAT))) ? SAT : quo_q[dsbc_pkg::MASS_W-1:0];

endmodule

// ----- sv/dempster_shafer_binary_combiner_core.sv -----
// combined evidence over {yes,no}: bit-serial multiply-accumulate, then
// bit-serial division in three lanes; an output register holds each result
// path to out_valid_o: a combination runs multiply, setup, divide and writeback, total
// conflict skips divide and writeback, a start item goes straight to done; each may then
// wait for the output register to drain; a new item is taken only once that result is loaded
// reset: combined state becomes vacuous belief (either = one, others zero), no result pending
`timescale 1ns / 1ps

module dempster_shafer_binary_combiner_core #(
  parameter int FRAC_BITS = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // evidence channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         start_req_i,
  input  logic [dsbc_pkg::MASS_W-1:0]  mass_yes_i,
  input  logic [dsbc_pkg::MASS_W-1:0]  mass_no_i,
  input  logic [dsbc_pkg::MASS_W-1:0]  mass_either_i,
  input  logic [dsbc_pkg::MASS_W-1:0]  mass_empty_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dsbc_pkg::MASS_W-1:0]  belief_o,
  output logic [dsbc_pkg::MASS_W-1:0]  plausibility_o,
  output logic [dsbc_pkg::MASS_W-1:0]  either_mass_o,
  output logic [dsbc_pkg::MASS_W-1:0]  conflict_mass_o,
  output logic                         total_conflict_o
);

  localparam int MW = dsbc_pkg::MASS_W;
  localparam int AW = dsbc_pkg::ACC_W;
  localparam int SW = dsbc_pkg::MUL_STEPS;
  localparam int CW = dsbc_pkg::CNT_W;
  // common compare width: holds any accumulator and one
  localparam int XW = AW + 1;
  localparam int DW = FRAC_BITS + 1;
  localparam logic [XW-1:0] ONE_X = XW'(64'd1 << FRAC_BITS);
  localparam logic [MW-1:0] SAT   = (FRAC_BITS <= 15) ? MW'(ONE_X) : '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_e;

  state_e state_q;

  // combined state
  logic [MW-1:0] comb_yes_q, comb_no_q, comb_either_q, comb_empty_q;
  // captured evidence and its pre-added multiplicands
  logic [MW-1:0] y2_q, n2_q;
  logic [MW:0]   yt2_q, nt2_q;
  logic [MW+1:0] s2_q;
  logic [MW-1:0] t2_q, e2_q;
  // multiplier shift registers, msb first
  logic [SW-1:0] my_q, mn_q, mt_q, me_q, ms_q;
  logic [AW-1:0] acc_y_q, acc_n_q, acc_t_q, acc_e_q;
  logic [CW-1:0] cnt_q;
  logic [MW-1:0] conflict_q;
  logic          flag_q;
  // output register
  logic          out_valid_q;
  logic [MW-1:0] belief_q, plaus_q, either_q, conflict_out_q;
  logic          total_q;

  logic                in_fire;
  logic [AW-1:0]       add_y, add_n, add_t, add_e;
  logic [XW-1:0]       qy, qn, qt, qe;
  logic                qe_lt_one;
  logic [DW-1:0]       denom;
  logic [MW-1:0]       cap_y, cap_n, cap_t, cap_e;
  logic [MW-1:0]       quo_y, quo_n, quo_t;
  logic [MW-1:0]       plaus;
  dsbc_pkg::div_ctrl_t div_ctrl;

  function automatic logic [MW-1:0] cap_f(input logic [XW-1:0] v);
    return (v > XW'(SAT)) ? SAT : v[MW-1:0];
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // one partial-product row per cycle for each combined mass
  assign add_y = (my_q[SW-1] ? AW'(yt2_q) : '0) + (mt_q[SW-1] ? AW'(y2_q) : '0);
  assign add_n = (mn_q[SW-1] ? AW'(nt2_q) : '0) + (mt_q[SW-1] ? AW'(n2_q) : '0);
  assign add_t = mt_q[SW-1] ? AW'(t2_q) : '0;
  assign add_e = (my_q[SW-1] ? AW'(n2_q) : '0) + (mn_q[SW-1] ? AW'(y2_q) : '0)
               + (me_q[SW-1] ? AW'(s2_q) : '0) + (ms_q[SW-1] ? AW'(e2_q) : '0);

  // truncate the products back to the mass scale
  assign qy = XW'(acc_y_q >> FRAC_BITS);
  assign qn = XW'(acc_n_q >> FRAC_BITS);
  assign qt = XW'(acc_t_q >> FRAC_BITS);
  assign qe = XW'(acc_e_q >> FRAC_BITS);

  assign cap_y     = cap_f(qy);
  assign cap_n     = cap_f(qn);
  assign cap_t     = cap_f(qt);
  assign cap_e     = cap_f(qe);
  assign qe_lt_one = qe < ONE_X;
  assign denom     = DW'(ONE_X - qe);

  assign div_ctrl.load = (state_q == ST_SETUP) && qe_lt_one;
  assign div_ctrl.step = (state_q == ST_DIV);

  dsbc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_yes (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (cap_y),
    .den_i  (denom),
    .quo_o  (quo_y)
  );

  dsbc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_no (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (cap_n),
    .den_i  (denom),
    .quo_o  (quo_n)
  );

  dsbc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_either (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (cap_t),
    .den_i  (denom),
    .quo_o  (quo_t)
  );

  // plausibility = one - no, floored at zero and capped
  assign plaus = (XW'(comb_no_q) >= ONE_X) ? '0 : cap_f(ONE_X - XW'(comb_no_q));

  // sequencer, combined state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      comb_yes_q     <= '0;
      comb_no_q      <= '0;
      comb_either_q  <= SAT;
      comb_empty_q   <= '0;
      conflict_q     <= '0;
      flag_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      belief_q       <= '0;
      plaus_q        <= '0;
      either_q       <= '0;
      conflict_out_q <= '0;
      total_q        <= 1'b0;
    end else begin
      // result transaction taken, and no new result loaded at this edge
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            flag_q <= 1'b0;
            cnt_q  <= '0;
            if (start_req_i) begin
              // first evidence is taken as the combined state
              comb_yes_q    <= mass_yes_i;
              comb_no_q     <= mass_no_i;
              comb_either_q <= mass_either_i;
              comb_empty_q  <= mass_empty_i;
              conflict_q    <= mass_empty_i;
              state_q       <= ST_DONE;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (cnt_q == CW'(SW - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_SETUP;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_SETUP: begin
          conflict_q <= cap_e;
          if (qe_lt_one) begin
            state_q <= ST_DIV;
          end else begin
            // total conflict: keep unnormalized masses
            comb_yes_q    <= cap_y;
            comb_no_q     <= cap_n;
            comb_either_q <= cap_t;
            comb_empty_q  <= cap_e;
            flag_q        <= 1'b1;
            state_q       <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (cnt_q == CW'(dsbc_pkg::QUO_W - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_WB;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_WB: begin
          comb_yes_q    <= quo_y;
          comb_no_q     <= quo_n;
          comb_either_q <= quo_t;
          comb_empty_q  <= '0;
          state_q       <= ST_DONE;
        end
        ST_DONE: begin
          // wait for the output register to be free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            belief_q       <= comb_yes_q;
            plaus_q        <= plaus;
            either_q       <= comb_either_q;
            conflict_out_q <= conflict_q;
            total_q        <= flag_q;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // multiply datapath: horner form, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      y2_q    <= mass_yes_i;
      n2_q    <= mass_no_i;
      t2_q    <= mass_either_i;
      e2_q    <= mass_empty_i;
      yt2_q   <= (MW+1)'(mass_yes_i) + (MW+1)'(mass_either_i);
      nt2_q   <= (MW+1)'(mass_no_i) + (MW+1)'(mass_either_i);
      s2_q    <= (MW+2)'(mass_yes_i) + (MW+2)'(mass_no_i)
               + (MW+2)'(mass_either_i) + (MW+2)'(mass_empty_i);
      my_q    <= SW'(comb_yes_q);
      mn_q    <= SW'(comb_no_q);
      mt_q    <= SW'(comb_either_q);
      me_q    <= SW'(comb_empty_q);
      ms_q    <= SW'(comb_yes_q) + SW'(comb_no_q) + SW'(comb_either_q);
      acc_y_q <= '0;
      acc_n_q <= '0;
      acc_t_q <= '0;
      acc_e_q <= '0;
    end else if (state_q == ST_MUL) begin
      my_q    <= {my_q[SW-2:0], 1'b0};
      mn_q    <= {mn_q[SW-2:0], 1'b0};
      mt_q    <= {mt_q[SW-2:0], 1'b0};
      me_q    <= {me_q[SW-2:0], 1'b0};
      ms_q    <= {ms_q[SW-2:0], 1'b0};
      acc_y_q <= {acc_y_q[AW-2:0], 1'b0} + add_y;
      acc_n_q <= {acc_n_q[AW-2:0], 1'b0} + add_n;
      acc_t_q <= {acc_t_q[AW-2:0], 1'b0} + add_t;
      acc_e_q <= {acc_e_q[AW-2:0], 1'b0} + add_e;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign belief_o         = belief_q;
  assign plausibility_o   = plaus_q;
  assign either_mass_o    = either_q;
  assign conflict_mass_o  = conflict_out_q;
  assign total_conflict_o = total_q;

`ifndef SYNTHESIS
  // a new result is only loaded from the done state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside done state");

  // division only runs when the conflict was below one
  a_div_no_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !flag_q)
    else $error("division running after total conflict");

  // a normalized writeback always clears the empty-set mass
  a_wb_clears_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WB) |=> (comb_empty_q == '0) && (state_q == ST_DONE))
    else $error("empty-set mass not cleared after normalization");

  // a start transaction loads the state and goes straight to the result
  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && start_req_i) |=>
      (state_q == ST_DONE) && (comb_yes_q == $past(mass_yes_i)) && !flag_q)
    else $error("start transaction did not load the combined state");

  // step counter stays inside the multiply length
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CW'(SW))
    else $error("step counter out of range");
`endif

endmodule

// ----- dv/testbench.sv -----
// testbench for dempster_shafer_binary_combiner_core: directed and random evidence
// checked against a cycle-free predictor held in a small scoreboard class
// depends on dsbc_pkg and the core module
`timescale 1ns / 1ps

module testbench;

  localparam int MASS_W = dsbc_pkg::MASS_W;
  localparam int FRAC_BITS = 15;
  localparam int MASS_ONE = 1 << FRAC_BITS;
  localparam int MASS_SAT = (MASS_ONE <= 65535) ? MASS_ONE : 65535;
  localparam int RANDOM_ITEMS = 1880;
  localparam int TAIL_ITEMS = 150;
  localparam int LONG_HOLD = 500;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [MASS_W-1:0] belief;
    logic [MASS_W-1:0] plausibility;
    logic [MASS_W-1:0] either_mass;
    logic [MASS_W-1:0] conflict_mass;
    logic              total_conflict;
  } outcome_t;

  // combined belief state plus the queue of outcomes still owed by the core
  class dempster_board;
    longint unsigned yes_m, no_m, either_m, empty_m;
    outcome_t awaited[$];
    int errors;

    function new();
      yes_m = 0;
      no_m = 0;
      either_m = MASS_SAT;
      empty_m = 0;
      errors = 0;
    endfunction

    function longint unsigned clip(longint unsigned v);
      return (v > MASS_SAT) ? MASS_SAT : v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // apply one accepted evidence and queue the outcome it must produce
    function void note_evidence(logic start, logic [MASS_W-1:0] y_in, logic [MASS_W-1:0] n_in,
                                logic [MASS_W-1:0] t_in, logic [MASS_W-1:0] e_in);
      longint unsigned y2, n2, t2, e2;
      longint unsigned py, pn, pt, pe, qy, qn, qt, qe, denom, conflict;
      outcome_t owed;
      logic flag;
      y2 = y_in;
      n2 = n_in;
      t2 = t_in;
      e2 = e_in;
      flag = 1'b0;
      if (start) begin
        yes_m = y2;
        no_m = n2;
        either_m = t2;
        empty_m = e2;
        conflict = e2;
      end else begin
        py = yes_m * y2 + yes_m * t2 + either_m * y2;
        pn = no_m * n2 + no_m * t2 + either_m * n2;
        pt = either_m * t2;
        pe = yes_m * n2 + no_m * y2 + empty_m * (y2 + n2 + t2 + e2)
             + (yes_m + no_m + either_m) * e2;
        qy = clip(py >> FRAC_BITS);
        qn = clip(pn >> FRAC_BITS);
        qt = clip(pt >> FRAC_BITS);
        qe = pe >> FRAC_BITS;
        conflict = clip(qe);
        if (qe < MASS_ONE) begin
          denom = MASS_ONE - qe;
          yes_m = clip((qy << FRAC_BITS) / denom);
          no_m = clip((qn << FRAC_BITS) / denom);
          either_m = clip((qt << FRAC_BITS) / denom);
          empty_m = 0;
        end else begin
          // total conflict: keep the raw masses, park the conflict on the empty set
          yes_m = qy;
          no_m = qn;
          either_m = qt;
          empty_m = conflict;
          flag = 1'b1;
        end
      end
      owed.belief = MASS_W'(yes_m);
      owed.plausibility = (no_m >= MASS_ONE) ? '0 : MASS_W'(clip(MASS_ONE - no_m));
      owed.either_mass = MASS_W'(either_m);
      owed.conflict_mass = MASS_W'(conflict);
      owed.total_conflict = flag;
      awaited.push_back(owed);
    endfunction

    function void match_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (awaited.size() == 0) begin
        $error("result transaction with no evidence outstanding, belief %0d", got.belief);
        errors++;
        return;
      end
      want = awaited.pop_front();
      match_field("belief", want.belief, got.belief);
      match_field("plausibility", want.plausibility, got.plausibility);
      match_field("either_mass", want.either_mass, got.either_mass);
      match_field("conflict_mass", want.conflict_mass, got.conflict_mass);
      match_field("total_conflict", want.total_conflict, got.total_conflict);
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              start_req_i;
  logic [MASS_W-1:0] mass_yes_i;
  logic [MASS_W-1:0] mass_no_i;
  logic [MASS_W-1:0] mass_either_i;
  logic [MASS_W-1:0] mass_empty_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [MASS_W-1:0] belief_o;
  logic [MASS_W-1:0] plausibility_o;
  logic [MASS_W-1:0] either_mass_o;
  logic [MASS_W-1:0] conflict_mass_o;
  logic              total_conflict_o;

  dempster_board board = new();
  outcome_t      seen_outcome;
  int            idle_pct = 0;
  bit            quiet_tail = 1'b0;
  bit            long_hold_done = 1'b0;
  int            results_seen = 0;

  dempster_shafer_binary_combiner_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .start_req_i     (start_req_i),
    .mass_yes_i      (mass_yes_i),
    .mass_no_i       (mass_no_i),
    .mass_either_i   (mass_either_i),
    .mass_empty_i    (mass_empty_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .belief_o        (belief_o),
    .plausibility_o  (plausibility_o),
    .either_mass_o   (either_mass_o),
    .conflict_mass_o (conflict_mass_o),
    .total_conflict_o(total_conflict_o)
  );

  always #10 clk_i = ~clk_i;

  // offer one evidence, optionally after an idle burst, and hold it until taken
  task automatic send_evidence(logic s, logic [MASS_W-1:0] y, logic [MASS_W-1:0] n,
                               logic [MASS_W-1:0] t, logic [MASS_W-1:0] e);
    int gap;
    if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    start_req_i <= s;
    mass_yes_i <= y;
    mass_no_i <= n;
    mass_either_i <= t;
    mass_empty_i <= e;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_evidence(s, y, n, t, e);
  endtask

  initial begin : evidence_source
    int a, b, c, m;
    logic s;
    logic [MASS_W-1:0] y, n, t, e;
    in_valid_i = 1'b0;
    start_req_i = 1'b0;
    mass_yes_i = '0;
    mass_no_i = '0;
    mass_either_i = '0;
    mass_empty_i = '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // combination straight out of reset, against vacuous belief
    send_evidence(1'b0, 16384, 8192, 8192, 0);
    send_evidence(1'b1, 0, 0, 0, 0);
    send_evidence(1'b0, 32768, 0, 0, 0);
    // certain yes against certain no: total conflict, then stays conflicted
    send_evidence(1'b1, 32768, 0, 0, 0);
    send_evidence(1'b0, 0, 32768, 0, 0);
    send_evidence(1'b0, 0, 0, 32768, 0);
    // masses above one everywhere
    send_evidence(1'b1, 65535, 65535, 65535, 65535);
    send_evidence(1'b0, 65535, 65535, 65535, 65535);
    // mass on no at and above one gives zero plausibility
    send_evidence(1'b1, 0, 65535, 0, 0);
    send_evidence(1'b1, 0, 32768, 0, 0);
    send_evidence(1'b1, 0, 0, 32768, 0);
    send_evidence(1'b0, 20000, 10000, 2768, 0);
    send_evidence(1'b0, 10000, 10000, 10000, 2768);
    send_evidence(1'b1, 16384, 16384, 0, 0);
    send_evidence(1'b0, 16384, 16384, 0, 0);
    // conflict one lsb below total: denominator of one saturates the quotients
    send_evidence(1'b1, 32768, 0, 0, 0);
    send_evidence(1'b0, 1, 32767, 0, 0);
    send_evidence(1'b1, 1, 1, 32766, 0);
    send_evidence(1'b0, 32767, 1, 0, 0);
    // start loading a full empty set, then combining evidence that sums to one is total conflict
    send_evidence(1'b1, 0, 0, 0, 32768);
    send_evidence(1'b0, 0, 0, 32768, 0);
    send_evidence(1'b1, 8000, 8000, 16768, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 50;
        endcase
      end
      if (i >= RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      if ($urandom_range(0, 99) < 85) begin
        // well-formed evidence: yes, no and either share at most one, empty mostly zero
        s = ($urandom_range(0, 9) == 0);
        a = $urandom_range(0, MASS_ONE);
        b = $urandom_range(0, MASS_ONE - a);
        c = MASS_ONE - a - b;
        if ($urandom_range(0, 3) == 0) c = $urandom_range(0, c);
        m = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2000) : 0;
        case ($urandom_range(0, 2))
          0: begin
            y = MASS_W'(a); n = MASS_W'(b); t = MASS_W'(c);
          end
          1: begin
            y = MASS_W'(b); n = MASS_W'(c); t = MASS_W'(a);
          end
          default: begin
            y = MASS_W'(c); n = MASS_W'(a); t = MASS_W'(b);
          end
        endcase
        e = MASS_W'(m);
      end else begin
        s = 1'($urandom_range(0, 1));
        y = MASS_W'($urandom);
        n = MASS_W'($urandom);
        t = MASS_W'($urandom);
        e = MASS_W'($urandom);
      end
      send_evidence(s, y, n, t, e);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold-off to back the core up
  initial begin : result_sink
    int hold_left;
    int stall_pct;
    int cycle_n;
    hold_left = 0;
    stall_pct = 10;
    cycle_n = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle_n++;
      if (cycle_n % 300 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 40;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (!long_hold_done && results_seen >= 300) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(1, 19) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_outcome.belief = belief_o;
      seen_outcome.plausibility = plausibility_o;
      seen_outcome.either_mass = either_mass_o;
      seen_outcome.conflict_mass = conflict_mass_o;
      seen_outcome.total_conflict = total_conflict_o;
      board.check_outcome(seen_outcome);
      results_seen++;
    end
  end

  // run ceiling, several times the slowest legal run
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
